>>> hw/rtl/spq_pkg.sv
// Shared types and status codes for the stable priority queue.
// Used by spq_cell and stable_priority_queue; depends on nothing.
package spq_pkg;

  localparam int IdWidth   = 16;
  localparam int PrioWidth = 16;
  localparam int StatWidth = 2;

  localparam logic [StatWidth-1:0] ST_ENQUEUED = 2'd0;
  localparam logic [StatWidth-1:0] ST_DEQUEUED = 2'd1;
  localparam logic [StatWidth-1:0] ST_EMPTY    = 2'd2;
  localparam logic [StatWidth-1:0] ST_FULL     = 2'd3;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  typedef struct packed {
    logic                        valid;
    logic [IdWidth-1:0]          id;
    logic signed [PrioWidth-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic                        fire;
    logic                        dequeue;
    logic [IdWidth-1:0]          id;
    logic signed [PrioWidth-1:0] prio;
  } cmd_t;

endpackage

>>> hw/rtl/spq_cell.sv
// One slot of the sorted shift-register queue.
// Depends on spq_pkg for entry_t and cmd_t.
module spq_cell (
  input  logic           clk,
  input  logic           rst,
  input  spq_pkg::cmd_t   cmd,
  input  spq_pkg::entry_t left_entry,
  input  logic           left_ge,
  input  spq_pkg::entry_t right_entry,
  output spq_pkg::entry_t entry,
  output logic           ge
);
  import spq_pkg::*;

  logic                        valid;
  logic                        valid_next;
  logic [IdWidth-1:0]          id;
  logic [IdWidth-1:0]          id_next;
  logic signed [PrioWidth-1:0] prio;
  logic signed [PrioWidth-1:0] prio_next;

  // The slot keeps its place when it holds an entry that ranks at or above the new one.
  assign ge = valid && (prio >= cmd.prio);

  always_comb begin
    valid_next = valid;
    id_next    = id;
    prio_next  = prio;
    priority if (!cmd.fire) begin
      valid_next = valid;
    end else if (cmd.dequeue) begin
      valid_next = right_entry.valid;
      id_next    = right_entry.id;
      prio_next  = right_entry.prio;
    end else if (ge) begin
      valid_next = valid;
    end else if (left_ge) begin
      valid_next = 1'b1;
      id_next    = cmd.id;
      prio_next  = cmd.prio;
    end else begin
      valid_next = left_entry.valid;
      id_next    = left_entry.id;
      prio_next  = left_entry.prio;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    id   <= id_next;
    prio <= prio_next;
  end

  assign entry.valid = valid;
  assign entry.id    = id;
  assign entry.prio  = prio;

endmodule

>>> hw/rtl/stable_priority_queue.sv
// Top level of the stable priority queue: a row of spq_cell slots and the result register.
// Depends on spq_pkg and spq_cell.
//
// Bounded priority queue of QUEUE_DEPTH entries kept sorted in a row of slots, slot 0 at the
// head. An enqueue beat goes behind every stored entry of equal or higher signed priority, so
// equal priorities leave in arrival order; a dequeue beat returns the head. Every input beat
// yields exactly one result beat, in the cycle after it is taken. The queue takes one beat per
// clock cycle: every slot compares its own priority with the new one and picks its next
// contents from itself, the new entry or a neighbor, all in the same cycle, and the result
// register accepts a new beat in the cycle its previous result is taken. The input is stalled
// only while a result waits under a stall.
module stable_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 operation,
  input  logic [spq_pkg::IdWidth-1:0]          entry_id,
  input  logic signed [spq_pkg::PrioWidth-1:0] entry_priority,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [spq_pkg::StatWidth-1:0]        status,
  output logic [spq_pkg::IdWidth-1:0]          head_id,
  output logic signed [spq_pkg::PrioWidth-1:0] head_priority
);
  import spq_pkg::*;

  entry_t                  entries [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]  ge;
  logic [QUEUE_DEPTH-1:0]  occ;
  cmd_t                    cmd;
  entry_t                  empty_entry;
  logic                    accept;
  logic                    full;
  logic                    empty;
  logic                    out_valid_next;
  logic [StatWidth-1:0]    status_next;
  logic [IdWidth-1:0]      head_id_next;
  logic signed [PrioWidth-1:0] head_priority_next;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = entries[QUEUE_DEPTH-1].valid;
  assign empty    = !entries[0].valid;

  assign empty_entry = '0;

  assign cmd.fire    = accept && !(operation == OP_ENQUEUE && full);
  assign cmd.dequeue = (operation == OP_DEQUEUE);
  assign cmd.id      = entry_id;
  assign cmd.prio    = entry_priority;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .left_entry ((i == 0) ? empty_entry : entries[(i == 0) ? 0 : i-1]),
      .left_ge    ((i == 0) ? 1'b1 : ge[(i == 0) ? 0 : i-1]),
      .right_entry((i == QUEUE_DEPTH-1) ? empty_entry
                                        : entries[(i == QUEUE_DEPTH-1) ? i : i+1]),
      .entry      (entries[i]),
      .ge         (ge[i])
    );
    assign occ[i] = entries[i].valid;
  end

  always_comb begin
    out_valid_next     = out_valid && out_stall;
    status_next        = status;
    head_id_next       = head_id;
    head_priority_next = head_priority;
    if (accept) begin
      out_valid_next     = 1'b1;
      head_id_next       = '0;
      head_priority_next = '0;
      unique case (operation)
        OP_DEQUEUE: begin
          if (empty) begin
            status_next = ST_EMPTY;
          end else begin
            status_next        = ST_DEQUEUED;
            head_id_next       = entries[0].id;
            head_priority_next = entries[0].prio;
          end
        end
        default: begin
          status_next = full ? ST_FULL : ST_ENQUEUED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    status        <= status_next;
    head_id       <= head_id_next;
    head_priority <= head_priority_next;
  end

  a_packed: assert property (@(posedge clk) disable iff (rst)
    (occ & (occ + QUEUE_DEPTH'(1))) == '0)
    else $error("Occupied slots are not packed at the head.");

  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_ENQUEUE && full) |=> (out_valid && status == ST_FULL))
    else $error("Enqueue into a full queue did not report full.");

  a_empty_deq: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_DEQUEUE && empty) |=>
      (out_valid && status == ST_EMPTY && head_id == '0))
    else $error("Dequeue from an empty queue did not report empty.");

  for (genvar k = 0; k + 1 < QUEUE_DEPTH; k++) begin : g_order_chk
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      entries[k+1].valid |-> (entries[k].prio >= entries[k+1].prio))
      else $error("Queue slots are out of priority order.");
  end

endmodule
